[src/reader_percentile_rank_unit_macros.svh]
// Assertion macros used by the reader percentile rank controller.
`ifndef READER_PERCENTILE_RANK_UNIT_MACROS_SVH
`define READER_PERCENTILE_RANK_UNIT_MACROS_SVH

// Check that a condition in one cycle leads to a consequence in the next.
`define RPR_ASSERT_NEXT(name, cond, rhs) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (rhs)) \
        else $error("rpr: sequence check failed");

// Check that a condition implies a consequence in the same cycle.
`define RPR_ASSERT_NOW(name, cond, rhs) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (rhs)) \
        else $error("rpr: same-cycle check failed");

`endif

[src/rpr_pkg.sv]
// Package: widths, constants and controller/datapath command and status types.
`timescale 1ns / 1ps
package rpr_pkg;

    localparam int USER_AW    = 12;
    localparam int USERS      = 4096;
    localparam int PAGE_W     = 10;
    localparam int HIST_DEPTH = 1024;
    localparam int CNT_W      = 13;
    localparam int FRAC_W     = 16;
    localparam int SHARE_W    = FRAC_W + 1;
    localparam int DIV_CW     = 5;

    localparam logic [DIV_CW-1:0]  DIV_FIRST = DIV_CW'(FRAC_W);
    localparam logic [SHARE_W-1:0] SHARE_ONE = SHARE_W'(1) << FRAC_W;

    typedef struct packed {
        logic ready;
        logic clr_wr;
        logic user_rd;
        logic old_cap;
        logic rec_upd;
        logic new_rd;
        logic new_inc;
        logic q_init;
        logic q_zero;
        logic q_one;
        logic sum_step;
        logic div_step;
        logic out_load;
    } rpr_cmd_t;

    typedef struct packed {
        logic in_fire;
        logic in_query;
        logic in_page_zero;
        logic act_query;
        logic old_zero;
        logic known_le1;
        logic idx_done;
        logic div_last;
        logic clr_last;
        logic out_free;
    } rpr_sts_t;

endpackage

[src/rpr_if.sv]
// Interfaces: input item channel and result channel.
`timescale 1ns / 1ps
interface rpr_item_if;
    logic                            valid;
    logic                            ready;
    logic                            action;
    logic [rpr_pkg::USER_AW-1:0]     user_id;
    logic [rpr_pkg::PAGE_W-1:0]      page_num;

    modport source (output valid, output action, output user_id, output page_num,
                    input ready);
    modport sink   (input valid, input action, input user_id, input page_num,
                    output ready);
endinterface

interface rpr_result_if;
    logic                            valid;
    logic                            ready;
    logic [rpr_pkg::SHARE_W-1:0]     share_fixed;

    modport source (output valid, output share_fixed, input ready);
    modport sink   (input valid, input share_fixed, output ready);
endinterface

[src/rpr_datapath.sv]
// Datapath: user and histogram memories, prefix sum, serial divider, output register.
`timescale 1ns / 1ps
module rpr_datapath
(
    input  logic              clk,
    input  logic              rst_n,
    input  rpr_pkg::rpr_cmd_t cmd,
    output rpr_pkg::rpr_sts_t sts,
    rpr_item_if.sink          item,
    rpr_result_if.source      result
);

    logic [rpr_pkg::PAGE_W-1:0]  user_mem [rpr_pkg::USERS];
    logic [rpr_pkg::CNT_W-1:0]   hist_mem [rpr_pkg::HIST_DEPTH];

    logic [rpr_pkg::USER_AW-1:0] uid_reg;
    logic [rpr_pkg::PAGE_W-1:0]  page_reg;
    logic                        act_reg;
    logic [rpr_pkg::PAGE_W-1:0]  old_reg;
    logic [rpr_pkg::PAGE_W-1:0]  idx_reg;
    logic [rpr_pkg::CNT_W-1:0]   acc_reg;
    logic [rpr_pkg::CNT_W-1:0]   acc_next;
    logic [rpr_pkg::SHARE_W-1:0] res_reg;
    logic [rpr_pkg::DIV_CW-1:0]  cnt_reg;
    logic [rpr_pkg::CNT_W-1:0]   known_reg;
    logic                        pend_reg;
    logic [rpr_pkg::USER_AW-1:0] clr_reg;
    logic                        out_valid_reg;
    logic [rpr_pkg::SHARE_W-1:0] out_data_reg;
    logic [rpr_pkg::PAGE_W-1:0]  user_rdata_reg;
    logic [rpr_pkg::CNT_W-1:0]   hist_rdata_reg;

    logic                        in_fire;
    logic                        idx_done;
    logic                        sum_issue;
    logic                        user_we;
    logic [rpr_pkg::USER_AW-1:0] user_waddr;
    logic [rpr_pkg::PAGE_W-1:0]  user_wdata;
    logic                        hist_we;
    logic [rpr_pkg::PAGE_W-1:0]  hist_waddr;
    logic [rpr_pkg::CNT_W-1:0]   hist_wdata;
    logic                        hist_rd;
    logic [rpr_pkg::PAGE_W-1:0]  hist_raddr;
    logic [rpr_pkg::CNT_W-1:0]   others;
    logic [rpr_pkg::CNT_W:0]     trial;
    logic                        ge;

    assign in_fire   = item.valid && item.ready;
    assign idx_done  = (idx_reg == old_reg);
    assign sum_issue = cmd.sum_step && !idx_done;

    assign item.ready         = cmd.ready;
    assign result.valid       = out_valid_reg;
    assign result.share_fixed = out_data_reg;

    always_comb
    begin
        sts              = '0;
        sts.in_fire      = in_fire;
        sts.in_query     = item.action;
        sts.in_page_zero = (item.page_num == '0);
        sts.act_query    = act_reg;
        sts.old_zero     = (old_reg == '0);
        sts.known_le1    = (known_reg <= rpr_pkg::CNT_W'(1));
        sts.idx_done     = idx_done;
        sts.div_last     = (cnt_reg == '0);
        sts.clr_last     = (&clr_reg);
        sts.out_free     = !out_valid_reg || result.ready;
    end

    // memory write and read ports
    always_comb
    begin
        user_we    = cmd.clr_wr || cmd.rec_upd;
        user_waddr = cmd.clr_wr ? clr_reg : uid_reg;
        user_wdata = cmd.clr_wr ? '0 : page_reg;

        hist_we    = cmd.clr_wr || cmd.new_inc ||
                     (cmd.rec_upd && (old_reg != '0) && (hist_rdata_reg != '0));
        if (cmd.clr_wr)
        begin
            hist_waddr = clr_reg[rpr_pkg::PAGE_W-1:0];
            hist_wdata = '0;
        end
        else if (cmd.rec_upd)
        begin
            hist_waddr = old_reg;
            hist_wdata = hist_rdata_reg - rpr_pkg::CNT_W'(1);
        end
        else
        begin
            hist_waddr = page_reg;
            hist_wdata = hist_rdata_reg + rpr_pkg::CNT_W'(1);
        end

        hist_rd = cmd.old_cap || cmd.new_rd || sum_issue;
        if (cmd.old_cap)
        begin
            hist_raddr = user_rdata_reg;
        end
        else if (cmd.new_rd)
        begin
            hist_raddr = page_reg;
        end
        else
        begin
            hist_raddr = idx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (user_we)
        begin
            user_mem[user_waddr] <= user_wdata;
        end
        if (cmd.user_rd)
        begin
            user_rdata_reg <= user_mem[uid_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        if (hist_rd)
        begin
            hist_rdata_reg <= hist_mem[hist_raddr];
        end
    end

    // accumulate and divide
    assign others = known_reg - rpr_pkg::CNT_W'(1);

    always_comb
    begin
        if (cnt_reg == rpr_pkg::DIV_FIRST)
        begin
            trial = {1'b0, acc_reg};
        end
        else
        begin
            trial = {acc_reg, 1'b0};
        end
        ge = (trial >= {1'b0, others});

        acc_next = acc_reg;
        if (cmd.q_init)
        begin
            acc_next = '0;
        end
        else if (cmd.sum_step && pend_reg)
        begin
            acc_next = acc_reg + hist_rdata_reg;
        end
        else if (cmd.div_step)
        begin
            acc_next = ge ? rpr_pkg::CNT_W'(trial - {1'b0, others})
                          : rpr_pkg::CNT_W'(trial);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            act_reg  <= item.action;
            uid_reg  <= item.user_id;
            page_reg <= item.page_num;
        end
        if (cmd.old_cap)
        begin
            old_reg <= user_rdata_reg;
        end
        if (cmd.q_init)
        begin
            idx_reg <= rpr_pkg::PAGE_W'(1);
            cnt_reg <= rpr_pkg::DIV_FIRST;
        end
        else
        begin
            if (sum_issue)
            begin
                idx_reg <= idx_reg + rpr_pkg::PAGE_W'(1);
            end
            if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg - rpr_pkg::DIV_CW'(1);
            end
        end
        acc_reg <= acc_next;
        if (cmd.q_zero)
        begin
            res_reg <= '0;
        end
        else if (cmd.q_one)
        begin
            res_reg <= rpr_pkg::SHARE_ONE;
        end
        else if (cmd.div_step)
        begin
            res_reg <= {res_reg[rpr_pkg::SHARE_W-2:0], ge};
        end
        if (cmd.out_load)
        begin
            out_data_reg <= res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            known_reg     <= '0;
            pend_reg      <= 1'b0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.rec_upd && (old_reg == '0))
            begin
                known_reg <= known_reg + rpr_pkg::CNT_W'(1);
            end
            pend_reg <= sum_issue;
            if (cmd.clr_wr)
            begin
                clr_reg <= clr_reg + rpr_pkg::USER_AW'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

[src/rpr_ctrl.sv]
// Controller: state machine sequencing clear, record, prefix sum and division.
`timescale 1ns / 1ps
`include "reader_percentile_rank_unit_macros.svh"
module rpr_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  rpr_pkg::rpr_sts_t sts,
    output rpr_pkg::rpr_cmd_t cmd
);

    typedef enum logic [10:0] {
        S_CLEAR = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_UREAD = 11'b00000000100,
        S_UDATA = 11'b00000001000,
        S_ODEC  = 11'b00000010000,
        S_NREAD = 11'b00000100000,
        S_NINC  = 11'b00001000000,
        S_QCHK  = 11'b00010000000,
        S_SUM   = 11'b00100000000,
        S_DIV   = 11'b01000000000,
        S_FIN   = 11'b10000000000
    } rpr_state_t;

    rpr_state_t state_reg;
    rpr_state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd.ready = 1'b1;
                if (sts.in_fire && (sts.in_query || !sts.in_page_zero))
                begin
                    state_next = S_UREAD;
                end
            end
            S_UREAD:
            begin
                cmd.user_rd = 1'b1;
                state_next  = S_UDATA;
            end
            S_UDATA:
            begin
                cmd.old_cap = 1'b1;
                state_next  = sts.act_query ? S_QCHK : S_ODEC;
            end
            S_ODEC:
            begin
                cmd.rec_upd = 1'b1;
                state_next  = S_NREAD;
            end
            S_NREAD:
            begin
                cmd.new_rd = 1'b1;
                state_next = S_NINC;
            end
            S_NINC:
            begin
                cmd.new_inc = 1'b1;
                state_next  = S_IDLE;
            end
            S_QCHK:
            begin
                cmd.q_init = 1'b1;
                if (sts.old_zero)
                begin
                    cmd.q_zero = 1'b1;
                    state_next = S_FIN;
                end
                else if (sts.known_le1)
                begin
                    cmd.q_one  = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                cmd.sum_step = 1'b1;
                if (sts.idx_done)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `RPR_ASSERT_NEXT(a_accept_starts, sts.in_fire && (sts.in_query || !sts.in_page_zero), state_reg == S_UREAD)
    `RPR_ASSERT_NEXT(a_clear_ends, (state_reg == S_CLEAR) && sts.clr_last, state_reg == S_IDLE)
    `RPR_ASSERT_NEXT(a_div_ends, (state_reg == S_DIV) && sts.div_last, state_reg == S_FIN)
    `RPR_ASSERT_NOW(a_load_free, cmd.out_load, sts.out_free)

endmodule

[src/reader_percentile_rank_unit.sv]
// Record: user memory read, then old-page decrement, new-page read and increment.
// Query: no division when the user is unknown or the sole user; one item at a time.
// Throughput is set by the prefix sum over the histogram memory (one entry per cycle)
// followed by a 17-step restoring divider.
// Reset: asynchronous, active low; a clearing pass over all 4096 user entries and the
// histogram memories follows, during which no item is accepted.
`timescale 1ns / 1ps
module reader_percentile_rank_unit
(
    input  logic         clk,
    input  logic         rst_n,
    rpr_item_if.sink     item,
    rpr_result_if.source result
);

    rpr_pkg::rpr_cmd_t cmd;
    rpr_pkg::rpr_sts_t sts;

    rpr_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    rpr_datapath u_datapath
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .sts    (sts),
        .item   (item),
        .result (result)
    );

endmodule
